FILE: rtl/tac_pkg.sv
// tac_pkg: shared types, widths and constants of the trunnion kinematics block
// depends on nothing; used by every module under rtl

package tac_pkg;

  // fixed field width and internal widths
  localparam int DW       = 32;
  localparam int CFG_IW   = 3;
  localparam int ANG_FRAC = 24;
  localparam int ZW       = 35;
  localparam int XW       = 34;
  localparam int TW       = 32;
  localparam int VW       = DW + 3;
  localparam int SW       = 40;
  localparam int QF       = 30;
  localparam int NSLOT    = 14;
  localparam int ATAN_N   = 32;
  localparam int RND_HALF = 1 << (QF - 1);

  localparam logic [1:0] MODE_TRUNNION = 2'd1;
  localparam logic       FUNC_INV      = 1'b1;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
  localparam logic signed [XW-1:0] TRIG_ONE    = XW'(1) <<< QF;
  localparam logic signed [ZW-1:0] ANG_HALF    = ZW'(180) <<< ANG_FRAC;
  localparam logic signed [ZW-1:0] ANG_QUARTER = ZW'(90) <<< ANG_FRAC;

  // atan(2^-i) in degrees, Q.24
  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_N] = '{
    35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
    35'sd60000934,  35'sd30029717,  35'sd15018523,  35'sd7509720,
    35'sd3754917,   35'sd1877466,   35'sd938734,    35'sd469367,
    35'sd234684,    35'sd117342,    35'sd58671,     35'sd29335,
    35'sd14668,     35'sd7334,      35'sd3667,      35'sd1833,
    35'sd917,       35'sd458,       35'sd229,       35'sd115,
    35'sd57,        35'sd29,        35'sd14,        35'sd7,
    35'sd4,         35'sd2,         35'sd1,         35'sd0
  };

  typedef enum logic [CFG_IW-1:0] {
    REG_MODE     = 3'd0,
    REG_PIVOT_X  = 3'd1,
    REG_PIVOT_Y  = 3'd2,
    REG_PIVOT_Z  = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5,
    REG_TOOL_LEN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]             kins_mode;
    logic signed [DW-1:0]   pivot_x;
    logic signed [DW-1:0]   pivot_y;
    logic signed [DW-1:0]   pivot_z;
    logic signed [DW-1:0]   offset_y;
    logic signed [DW-1:0]   offset_z;
    logic signed [DW-1:0]   tool_length;
  } kin_cfg_t;

  typedef struct packed {
    logic                 func;
    logic signed [DW-1:0] in_x;
    logic signed [DW-1:0] in_y;
    logic signed [DW-1:0] in_z;
    logic signed [DW-1:0] in_a;
    logic signed [DW-1:0] in_c;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] out_x;
    logic signed [DW-1:0] out_y;
    logic signed [DW-1:0] out_z;
    logic signed [DW-1:0] out_a;
    logic signed [DW-1:0] out_c;
    logic                 saturated;
  } out_item_t;

  // request fields that ride alongside the arithmetic
  typedef struct packed {
    logic                 func;
    logic                 trun;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] c;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic signed [ZW-1:0] za;
    logic signed [ZW-1:0] zc;
    logic                 flip_a;
    logic                 flip_c;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/trunnion_ac_kinematics.sv
// trunnion_ac_kinematics: top level, configuration registers and the front/queue/back split
// depends on tac_pkg, tac_front, tac_fifo, tac_back
//
//  channel | ports                                  | dir
//  --------+----------------------------------------+------------------
//  in      | in_valid, in_ready, in_data            | request in
//  out     | out_valid, out_ready, out_data         | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// one request per cycle sustained while the output is not stalled; the result path runs
// through the three-stage angle reduction, the queue slot, one cordic stage per step
// and six product/sum/saturate stages.
// synchronous active-low reset clears valids, queue pointers and all configuration registers to 0.
// an output stall freezes the back pipe; the front keeps accepting until the
// four-entry queue fills. cfg_ready is always high.

module trunnion_ac_kinematics #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tac_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tac_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tac_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [tac_pkg::DW-1:0]        cfg_data
);
  import tac_pkg::*;

  kin_cfg_t cfg_r;
  logic     push, pop;
  q_item_t  push_data, pop_data;
  q_stat_t  q_stat;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:     cfg_r.kins_mode   <= cfg_data[1:0];
        REG_PIVOT_X:  cfg_r.pivot_x     <= cfg_data;
        REG_PIVOT_Y:  cfg_r.pivot_y     <= cfg_data;
        REG_PIVOT_Z:  cfg_r.pivot_z     <= cfg_data;
        REG_OFFSET_Y: cfg_r.offset_y    <= cfg_data;
        REG_OFFSET_Z: cfg_r.offset_z    <= cfg_data;
        REG_TOOL_LEN: cfg_r.tool_length <= cfg_data;
        default: ;
      endcase
    end
  end

  tac_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .kins_mode (cfg_r.kins_mode),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  tac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  tac_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_data  (pop_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/tac_front.sv
// tac_front: accepts requests, tags the mode and reduces both angles to [-90,90]
// depends on tac_pkg; feeds tac_fifo

module tac_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tac_pkg::in_item_t in_data,
  input  logic [1:0]        kins_mode,
  input  tac_pkg::q_stat_t  q_stat,
  output logic              push,
  output tac_pkg::q_item_t  push_data
);
  import tac_pkg::*;

  localparam int IW   = DW - FRAC_BITS;
  localparam int IPW  = IW + 1;
  localparam int SH   = IW + 2;
  localparam int OFFS = 360 * (((1 << (IW - 1)) + 359) / 360);
  localparam logic [SH-1:0] RECIP = SH'((1 << SH) / 360);
  localparam int FSH  = ANG_FRAC - FRAC_BITS;

  logic v1_r, v2_r, v3_r;
  logic en;
  side_t side_in, s1_r, s2_r, s3_r;

  logic [IPW-1:0]          ipu2_r  [2];
  logic [IPW-1:0]          q2_r    [2];
  logic [FRAC_BITS-1:0]    frac2_r [2];
  logic signed [ZW-1:0]    z3_r    [2];
  logic                    flip3_r [2];

  // stall only when the last stage holds a request the queue cannot take
  assign en       = !v3_r || !q_stat.full;
  assign in_ready = en;
  assign push     = v3_r && !q_stat.full;

  // classify at accept
  always_comb begin
    side_in.func = in_data.func;
    side_in.trun = (kins_mode == MODE_TRUNNION);
    side_in.x    = in_data.in_x;
    side_in.y    = in_data.in_y;
    side_in.z    = in_data.in_z;
    side_in.a    = in_data.in_a;
    side_in.c    = in_data.in_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= side_in;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  // angle reduction mod 360 and fold into [-90,90]
  for (genvar g = 0; g < 2; g++) begin : g_ang
    logic signed [DW-1:0]  ang;
    logic [IPW-1:0]        ipu;
    logic [IPW+SH-1:0]     qprod;
    logic [IPW-1:0]        rem;
    logic [9:0]            rem10;
    logic [8:0]            rdeg;
    logic signed [ZW-1:0]  zr;
    logic signed [ZW-1:0]  zw;
    logic signed [ZW-1:0]  zf;
    logic                  fl;

    assign ang = (g == 0) ? s1_r.a : s1_r.c;

    // offset integer degrees to non-negative, quotient by reciprocal
    assign ipu   = IPW'(signed'(ang[DW-1:FRAC_BITS])) + IPW'(OFFS);
    assign qprod = ipu * RECIP;

    always_ff @(posedge clk) begin
      if (en) begin
        ipu2_r[g]  <= ipu;
        q2_r[g]    <= qprod[IPW+SH-1:SH];
        frac2_r[g] <= ang[FRAC_BITS-1:0];
      end
    end

    // remainder with one correction step
    assign rem   = ipu2_r[g] - IPW'(q2_r[g] * 10'd360);
    assign rem10 = rem[9:0];
    assign rdeg  = (rem10 >= 10'd360) ? 9'(rem10 - 10'd360) : rem10[8:0];
    assign zr    = ZW'({rdeg, frac2_r[g]}) <<< FSH;
    assign zw    = (zr >= ANG_HALF) ? zr - (ANG_HALF <<< 1) : zr;

    always_comb begin
      zf = zw;
      fl = 1'b0;
      if (zw > ANG_QUARTER) begin
        zf = ANG_HALF - zw;
        fl = 1'b1;
      end else if (zw < -ANG_QUARTER) begin
        zf = -ANG_HALF - zw;
        fl = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z3_r[g]    <= zf;
        flip3_r[g] <= fl;
      end
    end
  end

  always_comb begin
    push_data.side   = s3_r;
    push_data.za     = z3_r[0];
    push_data.zc     = z3_r[1];
    push_data.flip_a = flip3_r[0];
    push_data.flip_c = flip3_r[1];
  end

endmodule

FILE: rtl/tac_fifo.sv
// tac_fifo: short request queue between the front and back parts
// depends on tac_pkg

module tac_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tac_pkg::q_item_t push_data,
  input  logic             pop,
  output tac_pkg::q_item_t pop_data,
  output tac_pkg::q_stat_t q_stat
);
  import tac_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  q_item_t        mem_r [DEPTH];
  logic [AW-1:0]  wr_r, rd_r;
  logic [AW:0]    cnt_r;

  assign q_stat.full  = (cnt_r == (AW + 1)'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");

endmodule

FILE: rtl/tac_cordic.sv
// tac_cordic: pipelined rotation-mode cordic, one stage per step, degrees in Q.24
// depends on tac_pkg; gives clamped Q.30 sine and cosine

module tac_cordic #(
  parameter int STEPS = 20
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [tac_pkg::ZW-1:0] z_in,
  input  logic                          flip_in,
  output logic signed [tac_pkg::TW-1:0] sin_out,
  output logic signed [tac_pkg::TW-1:0] cos_out
);
  import tac_pkg::*;

  logic signed [XW-1:0] x_r [STEPS];
  logic signed [XW-1:0] y_r [STEPS];
  logic signed [ZW-1:0] z_r [STEPS-1];
  logic                 flip_r [STEPS];

  logic signed [XW-1:0] xl, yl, xc, yc;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    logic                 fi;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_in;
      assign fi = flip_in;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = flip_r[i-1];
    end

    // one micro-rotation
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i] <= fi;
        if (zi >= 0) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
        end
      end
    end

    if (i < STEPS - 1) begin : g_angle
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i] <= (zi >= 0) ? zi - ATAN_TAB[i] : zi + ATAN_TAB[i];
        end
      end
    end
  end

  // clamp to [-1,1] and undo the fold on cosine
  assign xl = x_r[STEPS-1];
  assign yl = y_r[STEPS-1];
  assign xc = (xl > TRIG_ONE) ? TRIG_ONE : ((xl < -TRIG_ONE) ? -TRIG_ONE : xl);
  assign yc = (yl > TRIG_ONE) ? TRIG_ONE : ((yl < -TRIG_ONE) ? -TRIG_ONE : yl);
  assign sin_out = TW'(yc);
  assign cos_out = flip_r[STEPS-1] ? TW'(-xc) : TW'(xc);

endmodule

FILE: rtl/tac_back.sv
// tac_back: trig, rotation products, sums and saturation, ending in the output register
// depends on tac_pkg and tac_cordic; pops requests from tac_fifo

module tac_back #(
  parameter int STEPS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tac_pkg::kin_cfg_t  cfg,
  input  tac_pkg::q_item_t   pop_data,
  input  tac_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tac_pkg::out_item_t out_data
);
  import tac_pkg::*;

  localparam int D   = STEPS + 6;
  localparam int PW  = VW + TW;
  localparam int PW2 = 2 * TW;

  function automatic logic signed [SW-1:0] rnd_term(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + PW'(RND_HALF) - PW'(p[PW-1]);
    return SW'(t >>> QF);
  endfunction

  function automatic logic signed [TW-1:0] rnd_trig(input logic signed [PW2-1:0] p);
    logic signed [PW2-1:0] t;
    t = p + PW2'(RND_HALF) - PW2'(p[PW2-1]);
    return TW'(t >>> QF);
  endfunction

  logic  en;
  logic  v_r  [D];
  side_t pl_r [D];

  logic signed [TW-1:0] sa_c, ca_c, sc_c, cc_c;

  // stage 1: trig and differences
  logic                 fwd1;
  logic signed [VW-1:0] ex1, ey1, ez1, dz1;
  logic signed [TW-1:0] sa1_r, ca1_r, sc1_r, cc1_r;
  logic signed [VW-1:0] ex1_r, ey1_r, ez1_r, dz1_r;

  // stage 2: trig cross products
  logic signed [TW-1:0] sa2_r, ca2_r, sc2_r, cc2_r;
  logic signed [TW-1:0] scca2_r, scsa2_r, ccca2_r, ccsa2_r;
  logic signed [VW-1:0] ex2_r, ey2_r, ez2_r, dz2_r;

  // stage 3 and 4: products, then rounding
  logic                 fwd3;
  logic signed [VW-1:0] offy;
  logic signed [VW-1:0] mv [NSLOT];
  logic signed [TW-1:0] mf [NSLOT];
  logic signed [PW-1:0] m3_r [NSLOT];
  logic signed [SW-1:0] t4_r [NSLOT];

  // stage 5: sums
  logic                 fwd5;
  logic signed [SW-1:0] kx, ky, kz, sx, sy, sz;
  logic signed [SW-1:0] sx5_r, sy5_r, sz5_r;

  // output stage
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (DW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (DW - 1));
  logic signed [SW-1:0] sv [3];
  logic signed [DW-1:0] so [3];
  logic                 ov [3];
  side_t                ps;
  out_item_t            out_nxt, out_r;

  assign en        = !v_r[D-1] || out_ready;
  assign pop       = !q_stat.empty && en;
  assign out_valid = v_r[D-1];
  assign out_data  = out_r;

  // valid and sideband shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= pop;
      for (int k = 1; k < D; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= pop_data.side;
      for (int k = 1; k < D; k++) pl_r[k] <= pl_r[k-1];
    end
  end

  tac_cordic #(.STEPS(STEPS)) u_cordic_a (
    .clk     (clk),
    .en      (en),
    .z_in    (pop_data.za),
    .flip_in (pop_data.flip_a),
    .sin_out (sa_c),
    .cos_out (ca_c)
  );

  tac_cordic #(.STEPS(STEPS)) u_cordic_c (
    .clk     (clk),
    .en      (en),
    .z_in    (pop_data.zc),
    .flip_in (pop_data.flip_c),
    .sin_out (sc_c),
    .cos_out (cc_c)
  );

  // offsets from the rotation point
  always_comb begin
    fwd1 = (pl_r[STEPS-1].func != FUNC_INV);
    dz1  = VW'(cfg.offset_z) + VW'(cfg.tool_length);
    ex1  = VW'(pl_r[STEPS-1].x) - VW'(cfg.pivot_x);
    if (fwd1) begin
      ey1 = VW'(pl_r[STEPS-1].y) - VW'(cfg.offset_y) - VW'(cfg.pivot_y);
      ez1 = VW'(pl_r[STEPS-1].z) - dz1 - VW'(cfg.pivot_z);
    end else begin
      ey1 = VW'(pl_r[STEPS-1].y) - VW'(cfg.pivot_y);
      ez1 = VW'(pl_r[STEPS-1].z) - VW'(cfg.pivot_z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa1_r <= sa_c;
      ca1_r <= ca_c;
      sc1_r <= sc_c;
      cc1_r <= cc_c;
      ex1_r <= ex1;
      ey1_r <= ey1;
      ez1_r <= ez1;
      dz1_r <= dz1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scca2_r <= rnd_trig(PW2'(sc1_r * ca1_r));
      scsa2_r <= rnd_trig(PW2'(sc1_r * sa1_r));
      ccca2_r <= rnd_trig(PW2'(cc1_r * ca1_r));
      ccsa2_r <= rnd_trig(PW2'(cc1_r * sa1_r));
      sa2_r   <= sa1_r;
      ca2_r   <= ca1_r;
      sc2_r   <= sc1_r;
      cc2_r   <= cc1_r;
      ex2_r   <= ex1_r;
      ey2_r   <= ey1_r;
      ez2_r   <= ez1_r;
      dz2_r   <= dz1_r;
    end
  end

  // multiplier operand selection per direction
  always_comb begin
    fwd3  = (pl_r[STEPS+1].func != FUNC_INV);
    offy  = VW'(cfg.offset_y);
    mv[0]  = ex2_r;  mf[0]  = cc2_r;
    mv[1]  = ey2_r;  mf[1]  = fwd3 ? scca2_r : sc2_r;
    mv[2]  = ez2_r;  mf[2]  = scsa2_r;
    mv[3]  = offy;   mf[3]  = sc2_r;
    mv[4]  = ex2_r;  mf[4]  = fwd3 ? sc2_r : scca2_r;
    mv[5]  = ey2_r;  mf[5]  = ccca2_r;
    mv[6]  = ez2_r;  mf[6]  = fwd3 ? ccsa2_r : sa2_r;
    mv[7]  = offy;   mf[7]  = fwd3 ? cc2_r : ca2_r;
    mv[8]  = dz2_r;  mf[8]  = sa2_r;
    mv[9]  = fwd3 ? ey2_r : ex2_r;
    mf[9]  = fwd3 ? sa2_r : scsa2_r;
    mv[10] = ez2_r;  mf[10] = ca2_r;
    mv[11] = ey2_r;  mf[11] = ccsa2_r;
    mv[12] = offy;   mf[12] = sa2_r;
    mv[13] = dz2_r;  mf[13] = ca2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NSLOT; j++) m3_r[j] <= PW'(mv[j] * mf[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NSLOT; j++) t4_r[j] <= rnd_term(m3_r[j]);
    end
  end

  // exact sums of rounded terms
  always_comb begin
    fwd5 = (pl_r[STEPS+3].func != FUNC_INV);
    kx   = SW'(cfg.pivot_x);
    kz   = SW'(cfg.offset_z) + SW'(cfg.tool_length) + SW'(cfg.pivot_z);
    if (fwd5) begin
      ky = SW'(cfg.pivot_y);
      sx = t4_r[0] + t4_r[1] + t4_r[2] + t4_r[3] + kx;
      sy = t4_r[5] - t4_r[4] + t4_r[6] + t4_r[7] + ky;
      sz = t4_r[10] - t4_r[9] + kz;
    end else begin
      ky = SW'(cfg.offset_y) + SW'(cfg.pivot_y);
      sx = t4_r[0] - t4_r[1] + kx;
      sy = t4_r[4] + t4_r[5] - t4_r[6] - t4_r[7] + t4_r[8] + ky;
      sz = t4_r[9] + t4_r[11] + t4_r[10] - t4_r[12] - t4_r[13] + kz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx5_r <= sx;
      sy5_r <= sy;
      sz5_r <= sz;
    end
  end

  // saturate, or pass through in identity mode
  always_comb begin
    ps    = pl_r[STEPS+4];
    sv[0] = sx5_r;
    sv[1] = sy5_r;
    sv[2] = sz5_r;
    for (int k = 0; k < 3; k++) begin
      ov[k] = 1'b0;
      so[k] = sv[k][DW-1:0];
      if (sv[k] > SAT_HI) begin
        ov[k] = 1'b1;
        so[k] = SAT_HI[DW-1:0];
      end else if (sv[k] < SAT_LO) begin
        ov[k] = 1'b1;
        so[k] = SAT_LO[DW-1:0];
      end
    end
    out_nxt.out_a = ps.a;
    out_nxt.out_c = ps.c;
    if (ps.trun) begin
      out_nxt.out_x     = so[0];
      out_nxt.out_y     = so[1];
      out_nxt.out_z     = so[2];
      out_nxt.saturated = ov[0] || ov[1] || ov[2];
    end else begin
      out_nxt.out_x     = ps.x;
      out_nxt.out_y     = ps.y;
      out_nxt.out_z     = ps.z;
      out_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  a_sat_only_trunnion: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[D-1] && out_r.saturated |-> pl_r[D-1].trun)
    else $error("saturation flagged outside trunnion mode");

  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> v_r[0]) else $error("popped request lost at pipe entry");

endmodule

FILE: verif/tac_checker.sv
// tac_checker: watches the request, result and register channels of the kinematics block,
// predicts every result in fixed point and compares it with the prediction; depends on tac_pkg

module tac_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  tac_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  tac_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tac_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [tac_pkg::DW-1:0]      cfg_data,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tac_pkg::*;

  localparam int STEPS = 20;

  // shadow copy of the registers
  logic [1:0] mode_q;
  longint     px, py, pz, offy, offz, tlen;
  out_item_t  pose_q[$];

  // sine and cosine of an angle in Q.16 degrees, both in Q.30
  function automatic void trig_deg(input longint ang, output longint s, output longint c);
    longint m, half, quarter, r, z, x, y, dx, dy;
    bit     flip;
    m = longint'(360) <<< 16;
    half = longint'(180) <<< ANG_FRAC;
    quarter = longint'(90) <<< ANG_FRAC;
    x = longint'(652032874);
    y = 0;
    flip = 0;
    r = ang % m;
    if (r < 0) r += m;
    z = r <<< (ANG_FRAC - 16);
    if (z >= half) z -= 2 * half;
    if (z > quarter) begin
      z = half - z;
      flip = 1;
    end else if (z < -quarter) begin
      z = -half - z;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    if (x > (longint'(1) <<< 30)) x = longint'(1) <<< 30;
    if (x < -(longint'(1) <<< 30)) x = -(longint'(1) <<< 30);
    if (y > (longint'(1) <<< 30)) y = longint'(1) <<< 30;
    if (y < -(longint'(1) <<< 30)) y = -(longint'(1) <<< 30);
    s = y;
    c = flip ? -x : x;
  endfunction

  // value times Q.30 factor, rounded half away from zero
  function automatic longint mul_q30(input longint v, input longint f);
    logic [127:0]    p;
    longint unsigned mv, mf;
    bit              neg;
    neg = (v < 0) != (f < 0);
    mv = (v < 0) ? -v : v;
    mf = (f < 0) ? -f : f;
    p = {64'd0, mv} * {64'd0, mf} + 128'(1 << 29);
    p = p >> 30;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clamp32(input longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // expected pose for one request under the current registers
  function automatic out_item_t predict_pose(input in_item_t rq);
    out_item_t r;
    longint    x, y, z, ox, oy, oz, sa, ca, sc, cc, dz, ex, ey, ez;
    longint    scca, scsa, ccca, ccsa;
    logic      flag;
    x = longint'(rq.in_x); y = longint'(rq.in_y); z = longint'(rq.in_z);
    ox = x; oy = y; oz = z;
    flag = 0;
    if (mode_q == MODE_TRUNNION) begin
      trig_deg(longint'(rq.in_a), sa, ca);
      trig_deg(longint'(rq.in_c), sc, cc);
      scca = mul_q30(sc, ca); scsa = mul_q30(sc, sa);
      ccca = mul_q30(cc, ca); ccsa = mul_q30(cc, sa);
      dz = offz + tlen;
      ex = x - px;
      if (rq.func != FUNC_INV) begin
        ey = y - offy - py;
        ez = z - dz - pz;
        ox = mul_q30(ex, cc) + mul_q30(ey, scca) + mul_q30(ez, scsa)
             + mul_q30(offy, sc) + px;
        oy = -mul_q30(ex, sc) + mul_q30(ey, ccca) + mul_q30(ez, ccsa)
             + mul_q30(offy, cc) + py;
        oz = -mul_q30(ey, sa) + mul_q30(ez, ca) + dz + pz;
      end else begin
        ey = y - py;
        ez = z - pz;
        ox = mul_q30(ex, cc) - mul_q30(ey, sc) + px;
        oy = mul_q30(ex, scca) + mul_q30(ey, ccca) - mul_q30(ez, sa)
             - mul_q30(offy, ca) + mul_q30(dz, sa) + offy + py;
        oz = mul_q30(ex, scsa) + mul_q30(ey, ccsa) + mul_q30(ez, ca)
             - mul_q30(offy, sa) - mul_q30(dz, ca) + dz + pz;
      end
      ox = clamp32(ox, flag);
      oy = clamp32(oy, flag);
      oz = clamp32(oz, flag);
    end
    r.out_x = ox[31:0];
    r.out_y = oy[31:0];
    r.out_z = oz[31:0];
    r.out_a = rq.in_a;
    r.out_c = rq.in_c;
    r.saturated = flag;
    return r;
  endfunction

  // track registers, queue predictions, compare results
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      mode_q <= '0;
      px = 0; py = 0; pz = 0; offy = 0; offz = 0; tlen = 0;
      pose_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     mode_q <= cfg_data[1:0];
          REG_PIVOT_X:  px = longint'($signed(cfg_data));
          REG_PIVOT_Y:  py = longint'($signed(cfg_data));
          REG_PIVOT_Z:  pz = longint'($signed(cfg_data));
          REG_OFFSET_Y: offy = longint'($signed(cfg_data));
          REG_OFFSET_Z: offz = longint'($signed(cfg_data));
          REG_TOOL_LEN: tlen = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          if (errors < 10) $display("%0t: result with no request waiting: %h", $realtime, out_data);
          errors <= errors + 1;
        end else begin
          e = pose_q.pop_front();
          if (out_data !== e) begin
            if (errors < 10) begin
              $display("%0t: mismatch x %h/%h y %h/%h z %h/%h", $realtime,
                       e.out_x, out_data.out_x, e.out_y, out_data.out_y,
                       e.out_z, out_data.out_z);
              $display("  a %h/%h c %h/%h sat %b/%b (expected/actual)",
                       e.out_a, out_data.out_a, e.out_c, out_data.out_c,
                       e.saturated, out_data.saturated);
            end
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) pose_q.push_back(predict_pose(in_data));
    end
    pending <= pose_q.size();
  end

endmodule

FILE: verif/tb_trunnion_ac_kinematics.sv
// tb_trunnion_ac_kinematics: stimulus, register phases and verdict for the kinematics block
// depends on tac_pkg, tac_checker and the rtl top trunnion_ac_kinematics

module tb_trunnion_ac_kinematics;
  timeunit 1ns;
  timeprecision 1ps;
  import tac_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN      = 40;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
  localparam int Q16 = 65536;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_ready;
  in_item_t    in_data = '0;
  logic        out_valid, out_ready = 0;
  out_item_t   out_data;
  logic        cfg_valid = 0, cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [DW-1:0]     cfg_data = '0;
  int          errors, pending;
  int          idle_cycles = 0;
  int          sent = 0;
  bit          hold_req = 0;

  always #5 clk = ~clk;

  trunnion_ac_kinematics dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tac_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    int r;
    @(posedge clk iff rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (r < 65) begin
        out_ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 0;
        repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // one request, with an optional idle gap before it
  task automatic send_request(input in_item_t rq, input int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= rq;
    forever begin
      @(negedge clk);
      if (in_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  // stop offering requests until every result has come back
  task automatic drain_all();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_regs(input logic [DW-1:0] mode, px, py, pz, oy, oz, tl);
    write_reg(REG_MODE, mode);
    write_reg(REG_PIVOT_X, px);
    write_reg(REG_PIVOT_Y, py);
    write_reg(REG_PIVOT_Z, pz);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_TOOL_LEN, tl);
  endtask

  function automatic logic [DW-1:0] rand_coord();
    if ($urandom_range(0, 99) < 85)
      return DW'($urandom_range(0, 3000 * Q16) - 1500 * Q16);
    return $urandom;
  endfunction

  function automatic logic [DW-1:0] rand_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return DW'(90 * Q16 * $urandom_range(0, 8)) - DW'(360 * Q16);
    if (r < 85) return DW'($urandom_range(0, 1600 * Q16) - 800 * Q16);
    return $urandom;
  endfunction

  function automatic in_item_t rand_request();
    in_item_t rq;
    rq.func = 1'($urandom_range(0, 1));
    rq.in_x = rand_coord();
    rq.in_y = rand_coord();
    rq.in_z = rand_coord();
    rq.in_a = rand_angle();
    rq.in_c = rand_angle();
    return rq;
  endfunction

  // extremes of the fields and the quadrant angles, both directions
  task automatic directed_set();
    in_item_t rq;
    logic [DW-1:0] angs [10];
    angs = '{0, 90 * Q16, 180 * Q16, 270 * Q16, 360 * Q16, -90 * Q16, 45 * Q16,
             32'h8000_0000, 32'h7FFF_FFFF, -720 * Q16};
    for (int i = 0; i < 10; i++) begin
      rq.func = i[0];
      rq.in_x = (i % 3 == 0) ? 32'h7FFF_FFFF : (i % 3 == 1) ? 32'h8000_0000 : 32'd0;
      rq.in_y = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      rq.in_z = (i < 5) ? 32'h7FFF_FFFF : 32'h8000_0000;
      rq.in_a = angs[i];
      rq.in_c = angs[9 - i];
      send_request(rq, 0);
    end
    for (int i = 0; i < 6; i++) begin
      rq = rand_request();
      rq.func = i[0];
      rq.in_a = angs[i];
      rq.in_c = angs[i + 1];
      send_request(rq, i % 2);
    end
  endtask

  task automatic random_run(input int n, input bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_req = 1;
      if (i == n / 2) drain_all();
      send_request(rand_request(), pick_gap());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // identity after reset
    directed_set();
    random_run(120, 0);
    drain_all();

    // trunnion, moderate pivot and offsets
    set_regs(32'h0000_0001, 120 * Q16, -35 * Q16, 80 * Q16 + 1234, 15 * Q16, 60 * Q16,
             90 * Q16 + 77);
    directed_set();
    random_run(230, 1);
    drain_all();

    // trunnion, register extremes to force clamping
    set_regs(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h8000_0000);
    random_run(150, 0);
    drain_all();

    // trunnion, random registers, mostly of small size
    set_regs(32'h0000_0001, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord());
    random_run(220, 1);
    drain_all();

    // modes that act as identity, upper data bits ignored, unused index
    set_regs(32'hFFFF_FFFE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    write_reg(REG_UNUSED, $urandom);
    random_run(100, 0);
    drain_all();
    write_reg(REG_MODE, 32'h0000_0003);
    random_run(100, 0);
    drain_all();

    // back to trunnion with zero offsets
    set_regs(32'h0000_0001, 0, 0, 0, 0, 0, 0);
    directed_set();
    random_run(150, 0);
    drain_all();

    $display("covered %0d requests over identity and trunnion modes, both directions,", sent);
    $display("register extremes with clamping, stalls and long result hold-offs");
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
